/* sv/tick_task_timer_table_assert.svh */
// Assertion macros for the tick task timer table.
`ifndef TICK_TASK_TIMER_TABLE_ASSERT_SVH
`define TICK_TASK_TIMER_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define TTT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tick_task_timer_table: assertion failed");

`define TTT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tick_task_timer_table: assertion failed");

`else

`define TTT_ASSERT_SAME(lbl, ante, cons)

`define TTT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* sv/ttt_pkg.sv */
// Shared types, codes and constants of the tick task timer table.
`timescale 1ns / 1ps

package ttt_pkg;

    localparam int MAX_TASKS_DEF = 32;

    localparam int MODE_W  = 2;
    localparam int OWNER_W = 4;
    localparam int ID_W    = 32;
    localparam int DELAY_W = 24;
    localparam int TICK_W  = 48;
    localparam int MASK_W  = 16;
    localparam int KIND_W  = 2;

    localparam logic [MASK_W-1:0] MASK_RESET = 16'hFFFF;

    typedef logic [OWNER_W-1:0] owner_t;
    typedef logic [ID_W-1:0]    id_t;
    typedef logic [DELAY_W-1:0] delay_t;
    typedef logic [TICK_W-1:0]  tick_t;
    typedef logic [MASK_W-1:0]  mask_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_SCHED        = 2'd0,
        MODE_CANCEL_ID    = 2'd1,
        MODE_CANCEL_OWNER = 2'd2,
        MODE_TICK         = 2'd3
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_SCHED_ACK  = 2'd0,
        KIND_CANCEL_ACK = 2'd1,
        KIND_FIRED      = 2'd2,
        KIND_TICK_END   = 2'd3
    } kind_t;

    typedef struct packed {
        id_t    id;
        owner_t owner;
        tick_t  due;
        delay_t period;
    } slot_t;

    typedef struct packed {
        kind_t kind;
        id_t   id;
        logic  status;
        logic  last;
    } res_t;

endpackage

/* sv/ttt_ifs.sv */
// Request and response channel interfaces of the tick task timer table.
`timescale 1ns / 1ps

interface ttt_req_if;
    logic                         valid;
    logic                         ready;
    logic [ttt_pkg::MODE_W-1:0]   mode;
    logic [ttt_pkg::OWNER_W-1:0]  owner;
    logic [ttt_pkg::ID_W-1:0]     task_id;
    logic [ttt_pkg::DELAY_W-1:0]  delay;
    logic [ttt_pkg::DELAY_W-1:0]  period;

    modport source (output valid, mode, owner, task_id, delay, period, input ready);
    modport sink (input valid, mode, owner, task_id, delay, period, output ready);
endinterface

interface ttt_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ttt_pkg::KIND_W-1:0]   kind;
    logic [ttt_pkg::ID_W-1:0]     result_id;
    logic                         status;
    logic                         last;

    modport source (output valid, kind, result_id, status, last, input ready);
    modport sink (input valid, kind, result_id, status, last, output ready);
endinterface

/* sv/ttt_slot_ram.sv */
// Slot table memory with one write port and one registered read port.
`timescale 1ns / 1ps

module ttt_slot_ram #(
    parameter int MAX_TASKS = ttt_pkg::MAX_TASKS_DEF,
    localparam int IdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [IdxW-1:0]  rd_addr,
    output ttt_pkg::slot_t   rd_data,
    input  logic             wr_en,
    input  logic [IdxW-1:0]  wr_addr,
    input  ttt_pkg::slot_t   wr_data
);

    ttt_pkg::slot_t mem [MAX_TASKS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* sv/ttt_engine.sv */
// Request sequencer: free slot search, cancel scan and tick scan over the slot memory.
`timescale 1ns / 1ps

module ttt_engine #(
    parameter int MAX_TASKS = ttt_pkg::MAX_TASKS_DEF,
    localparam int IdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    ttt_req_if.sink          req,
    input  ttt_pkg::mask_t   mask,
    output logic             res_valid,
    input  logic             res_ready,
    output ttt_pkg::res_t    res,
    output logic             rd_en,
    output logic [IdxW-1:0]  rd_addr,
    input  ttt_pkg::slot_t   rd_data,
    output logic             wr_en,
    output logic [IdxW-1:0]  wr_addr,
    output ttt_pkg::slot_t   wr_data
);

    localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_TASKS - 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_FIND = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [MAX_TASKS-1:0]   valid_reg, valid_next;
    logic [IdxW-1:0]        idx_reg, idx_next;
    logic                   issue_done_reg, issue_done_next;
    logic                   ev_valid_reg, ev_valid_next;
    logic [IdxW-1:0]        ev_idx_reg, ev_idx_next;
    ttt_pkg::tick_t         tick_reg, tick_next;
    ttt_pkg::id_t           next_id_reg, next_id_next;

    ttt_pkg::mode_t         op_mode_reg, op_mode_next;
    ttt_pkg::owner_t        op_owner_reg, op_owner_next;
    ttt_pkg::id_t           op_id_reg, op_id_next;
    ttt_pkg::delay_t        op_delay_reg, op_delay_next;
    ttt_pkg::delay_t        op_period_reg, op_period_next;
    ttt_pkg::res_t          fin_reg, fin_next;

    logic                   accept;
    logic                   ev_live;
    logic                   hit_cancel;
    logic                   fire;
    logic                   stall;
    ttt_pkg::delay_t        delay_eff;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);

    assign ev_live = ev_valid_reg && valid_reg[ev_idx_reg] && (state_reg == ST_SCAN);
    assign hit_cancel = ev_live
        && (((op_mode_reg == ttt_pkg::MODE_CANCEL_ID) && (rd_data.id == op_id_reg))
        || ((op_mode_reg == ttt_pkg::MODE_CANCEL_OWNER) && (rd_data.owner == op_owner_reg)));
    assign fire = ev_live && (op_mode_reg == ttt_pkg::MODE_TICK)
        && (rd_data.due <= tick_reg) && mask[rd_data.owner];
    assign stall = fire && !res_ready;
    assign delay_eff = (op_delay_reg == '0) ? ttt_pkg::delay_t'(1) : op_delay_reg;

    assign res_valid = (state_reg == ST_DONE) || fire;

    always_comb
    begin
        if (state_reg == ST_DONE)
        begin
            res = fin_reg;
        end
        else
        begin
            res.kind   = ttt_pkg::KIND_FIRED;
            res.id     = rd_data.id;
            res.status = 1'b0;
            res.last   = 1'b0;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        idx_next        = idx_reg;
        issue_done_next = issue_done_reg;
        ev_valid_next   = ev_valid_reg;
        ev_idx_next     = ev_idx_reg;
        tick_next       = tick_reg;
        next_id_next    = next_id_reg;
        op_mode_next    = op_mode_reg;
        op_owner_next   = op_owner_reg;
        op_id_next      = op_id_reg;
        op_delay_next   = op_delay_reg;
        op_period_next  = op_period_reg;
        fin_next        = fin_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data.id      = next_id_reg;
        wr_data.owner   = op_owner_reg;
        wr_data.due     = tick_reg + ttt_pkg::tick_t'(delay_eff);
        wr_data.period  = op_period_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_mode_next    = ttt_pkg::mode_t'(req.mode);
                    op_owner_next   = req.owner;
                    op_id_next      = req.task_id;
                    op_delay_next   = req.delay;
                    op_period_next  = req.period;
                    idx_next        = '0;
                    issue_done_next = 1'b0;
                    ev_valid_next   = 1'b0;
                    fin_next.status = 1'b0;
                    fin_next.last   = 1'b1;
                    fin_next.id     = '0;
                    unique case (ttt_pkg::mode_t'(req.mode))
                        ttt_pkg::MODE_SCHED:
                        begin
                            fin_next.kind = ttt_pkg::KIND_SCHED_ACK;
                            state_next    = ST_FIND;
                        end
                        ttt_pkg::MODE_CANCEL_ID:
                        begin
                            fin_next.kind = ttt_pkg::KIND_CANCEL_ACK;
                            fin_next.id   = req.task_id;
                            state_next    = ST_SCAN;
                        end
                        ttt_pkg::MODE_CANCEL_OWNER:
                        begin
                            fin_next.kind = ttt_pkg::KIND_CANCEL_ACK;
                            state_next    = ST_SCAN;
                        end
                        ttt_pkg::MODE_TICK:
                        begin
                            fin_next.kind = ttt_pkg::KIND_TICK_END;
                            tick_next     = tick_reg + ttt_pkg::tick_t'(1);
                            state_next    = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FIND:
            begin
                if (!valid_reg[idx_reg])
                begin
                    wr_en               = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                    fin_next.id         = next_id_reg;
                    next_id_next        = next_id_reg + ttt_pkg::id_t'(1);
                    state_next          = ST_DONE;
                end
                else if (idx_reg == LastIdx)
                begin
                    fin_next.status = 1'b1;
                    state_next      = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + IdxW'(1);
                end
            end
            ST_SCAN:
            begin
                if (!stall)
                begin
                    if (hit_cancel)
                    begin
                        valid_next[ev_idx_reg] = 1'b0;
                    end
                    if (fire)
                    begin
                        if (rd_data.period == '0)
                        begin
                            valid_next[ev_idx_reg] = 1'b0;
                        end
                        else
                        begin
                            wr_en          = 1'b1;
                            wr_addr        = ev_idx_reg;
                            wr_data.id     = rd_data.id;
                            wr_data.owner  = rd_data.owner;
                            wr_data.due    = tick_reg + ttt_pkg::tick_t'(rd_data.period);
                            wr_data.period = rd_data.period;
                        end
                    end
                    ev_valid_next = !issue_done_reg;
                    ev_idx_next   = idx_reg;
                    if (!issue_done_reg)
                    begin
                        rd_en = 1'b1;
                        if (idx_reg == LastIdx)
                        begin
                            issue_done_next = 1'b1;
                        end
                        else
                        begin
                            idx_next = idx_reg + IdxW'(1);
                        end
                    end
                    else if (!ev_valid_reg)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            idx_reg        <= '0;
            issue_done_reg <= 1'b0;
            ev_valid_reg   <= 1'b0;
            ev_idx_reg     <= '0;
            tick_reg       <= '0;
            next_id_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            idx_reg        <= idx_next;
            issue_done_reg <= issue_done_next;
            ev_valid_reg   <= ev_valid_next;
            ev_idx_reg     <= ev_idx_next;
            tick_reg       <= tick_next;
            next_id_reg    <= next_id_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_mode_reg   <= op_mode_next;
        op_owner_reg  <= op_owner_next;
        op_id_reg     <= op_id_next;
        op_delay_reg  <= op_delay_next;
        op_period_reg <= op_period_next;
        fin_reg       <= fin_next;
    end

endmodule

/* sv/tick_task_timer_table.sv */
// Top level of the tick task timer table: enable mask, slot memory, sequencer, result register.
`timescale 1ns / 1ps
`include "tick_task_timer_table_assert.svh"

// The block keeps MAX_TASKS timed tasks and takes one request at a time on req:
// schedule, cancel by id, cancel by owner, or tick. Results leave on rsp, and
// every request ends with exactly one result that has last set.
// Schedule searches the valid bits one slot per cycle, then sends its acknowledge
// through the output register to rsp.
// Cancel and tick walk the slot memory one entry per cycle through its single
// read port, unless the receiver stalls a fired result; a tick emits one fired
// result per due task whose owner is enabled in the mask, in ascending slot
// order, then a tick end result.
// A new request is taken only when the previous one has handed its last result
// to the output register, so a waiting result does not block the next transfer.
// When the receiver stalls, the output register holds its result and the scan
// pauses on the next task that is due to fire.
// The user must write the owner enable mask through cfg_wr_en and cfg_wr_data only while the
// block is idle; the block does not enforce this. Reset clears the valid bits, the tick count
// and the id counter and sets the mask to all ones; the slot memory itself is not cleared.
module tick_task_timer_table #(
    parameter int MAX_TASKS = ttt_pkg::MAX_TASKS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    ttt_req_if.sink                      req,
    ttt_rsp_if.source                    rsp,
    input  logic                         cfg_wr_en,
    input  logic [ttt_pkg::MASK_W-1:0]   cfg_wr_data
);

    localparam int IdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    ttt_pkg::mask_t   mask_reg;
    logic             out_valid_reg;
    ttt_pkg::res_t    out_reg;

    logic             res_valid;
    logic             res_ready;
    ttt_pkg::res_t    res;
    logic             rd_en;
    logic [IdxW-1:0]  rd_addr;
    ttt_pkg::slot_t   rd_data;
    logic             wr_en;
    logic [IdxW-1:0]  wr_addr;
    ttt_pkg::slot_t   wr_data;

    ttt_engine #(
        .MAX_TASKS (MAX_TASKS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .mask      (mask_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    ttt_slot_ram #(
        .MAX_TASKS (MAX_TASKS)
    ) u_slot_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= ttt_pkg::MASK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mask_reg <= cfg_wr_data;
            end
            if (res_ready)
            begin
                out_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.kind      = out_reg.kind;
    assign rsp.result_id = out_reg.id;
    assign rsp.status    = out_reg.status;
    assign rsp.last      = out_reg.last;

    `TTT_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
    `TTT_ASSERT_SAME(a_no_result_when_idle, req.ready, !res_valid)
    `TTT_ASSERT_NEXT(a_result_lands, res_valid && res_ready, rsp.valid)
    `TTT_ASSERT_SAME(a_ack_is_last, rsp.valid && (rsp.kind != ttt_pkg::KIND_FIRED), rsp.last)

endmodule
